@@ hdl/gec_pkg.sv @@
// Shared types, constants and the tempering function for the Gilbert-Elliott channel.
// No dependencies.
package gec_pkg;

  localparam logic [31:0] MT_MULT  = 32'd1812433253;
  localparam logic [31:0] MT_MAG   = 32'h9908B0DF;
  localparam logic [31:0] RECIP3   = 32'hAAAAAAAB;  // ceil(2^33 / 3)
  localparam int          TW_SHIFT = 397;

  localparam logic [2:0] REG_SEED      = 3'd0;
  localparam logic [2:0] REG_ERASE     = 3'd1;
  localparam logic [2:0] REG_ENTER_BAD = 3'd2;
  localparam logic [2:0] REG_LEAVE_BAD = 3'd3;
  localparam logic [2:0] REG_MODE      = 3'd4;
  localparam logic [2:0] REG_LENGTH    = 3'd5;

  typedef enum logic [11:0] {
    ST_SEED0 = 12'b000000000001,
    ST_SMUL  = 12'b000000000010,
    ST_SWR   = 12'b000000000100,
    ST_IDLE  = 12'b000000001000,
    ST_DIVA  = 12'b000000010000,
    ST_DIVB  = 12'b000000100000,
    ST_DIVC  = 12'b000001000000,
    ST_RD0   = 12'b000010000000,
    ST_RD1   = 12'b000100000000,
    ST_RD2   = 12'b001000000000,
    ST_GEN   = 12'b010000000000,
    ST_DONE  = 12'b100000000000
  } state_t;

  function automatic logic [31:0] temper(input logic [31:0] v);
    logic [31:0] y;
    y = v ^ (v >> 11);
    y = y ^ ((y << 7) & 32'h9D2C5680);
    y = y ^ ((y << 15) & 32'hEFC60000);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

@@ hdl/gec_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gec_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hdl/gilbert_elliott_erasure_channel.sv @@
// Gilbert-Elliott erasure channel driven by an MT19937 generator held in one RAM.
// Depends on gec_pkg and gec_ram.
// Sequence: a tick runs the setup states DIVA, DIVB and DIVC, then RD0, RD1, RD2 and GEN
//   for each twister word (4 words in the good state, 2 in the bad state), then DONE.
//   A restart runs a seeding pass (SEED0, then SMUL and SWR for each further word) first.
// Flow: one item at a time; a new tick is taken only in IDLE, and DONE waits while the
//   output stalls. The RAM port (three reads and one write per word) sets the pace.
// Reset (synchronous): registers take their reset values and the twister is seeded
//   from 5489 in a seeding pass during which s_tready stays low.
module gilbert_elliott_erasure_channel
  import gec_pkg::*;
#(
  parameter int TWISTER_WORDS = 624
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] restart
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] erased, [1] in_good_state
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  localparam int AW = $clog2(TWISTER_WORDS);
  localparam logic [AW-1:0] LAST_IDX = AW'(TWISTER_WORDS - 1);
  localparam logic [AW-1:0] SHIFT    = AW'(TW_SHIFT);
  localparam logic [AW-1:0] WRAP     = AW'(TWISTER_WORDS - TW_SHIFT);

  // configuration
  logic [31:0] rng_seed;
  logic [63:0] erase_threshold, enter_bad_threshold, leave_bad_threshold;
  logic        burst_mode;
  logic [30:0] sequence_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      rng_seed            <= 32'd5489;
      erase_threshold     <= '0;
      enter_bad_threshold <= '0;
      leave_bad_threshold <= '0;
      burst_mode          <= 1'b0;
      sequence_length     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEED:      rng_seed            <= cfg_data[31:0];
        REG_ERASE:     erase_threshold     <= cfg_data;
        REG_ENTER_BAD: enter_bad_threshold <= cfg_data;
        REG_LEAVE_BAD: leave_bad_threshold <= cfg_data;
        REG_MODE:      burst_mode          <= cfg_data[0];
        REG_LENGTH:    sequence_length     <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  state_t      state;
  logic [AW-1:0] idx;        // twister index, also the seeding counter
  logic [1:0]  wc;           // words taken in this tick
  logic [31:0] p;            // previous seed word
  logic [31:0] w0, w1;       // mt[k] and mt[k+1]
  logic [31:0] lo;           // low half of the draw
  logic [63:0] prod;         // shared multiplier output
  logic [30:0] third, two_third;
  logic [30:0] position;
  logic        good, erased, tick;

  // shared multiplier: seeding step or reciprocal divide by three
  logic [31:0] mul_a, mul_b;
  always_comb begin
    mul_a = RECIP3;
    mul_b = {sequence_length, 1'b0};
    case (state)
      ST_SMUL: begin
        mul_a = MT_MULT;
        mul_b = p ^ (p >> 30);
      end
      ST_DIVA: mul_b = {1'b0, sequence_length};
      default: ;
    endcase
  end
  always_ff @(posedge clk) prod <= 64'(mul_a) * 64'(mul_b);

  // RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr, idx_next1, idx_shift;
  logic [31:0]   ram_wdata, ram_rdata, seed_val, y, v, t;
  logic [63:0]   d;
  logic          middle;

  assign idx_next1 = (idx == LAST_IDX) ? '0 : idx + 1'b1;
  assign idx_shift = (idx >= WRAP) ? idx - WRAP : idx + SHIFT;
  assign seed_val  = prod[31:0] + 32'(idx);
  assign y         = {w0[31], w1[30:0]};
  assign v         = ram_rdata ^ (y >> 1) ^ (y[0] ? MT_MAG : 32'd0);
  assign t         = temper(v);
  assign d         = {t, lo};
  assign middle    = burst_mode && (position >= third) && (position <= two_third);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = v;
    ram_raddr = idx;
    case (state)
      ST_SEED0: begin
        ram_we    = 1'b1;
        ram_wdata = rng_seed;
      end
      ST_SWR: begin
        ram_we    = 1'b1;
        ram_wdata = seed_val;
      end
      ST_RD1:  ram_raddr = idx_next1;
      ST_RD2:  ram_raddr = idx_shift;
      ST_GEN:  ram_we    = 1'b1;
      default: ;
    endcase
  end

  gec_ram #(.WIDTH(32), .DEPTH(TWISTER_WORDS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_SEED0;
      idx      <= '0;
      wc       <= '0;
      good     <= 1'b1;
      erased   <= 1'b0;
      tick     <= 1'b0;
      position <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_SEED0: begin
          p     <= rng_seed;
          idx   <= AW'(1);
          state <= ST_SMUL;
        end
        ST_SMUL: state <= ST_SWR;
        ST_SWR: begin
          p <= seed_val;
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= tick ? ST_DIVA : ST_IDLE;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_SMUL;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            tick <= 1'b1;
            if (s_tdata[0]) begin
              position <= '0;
              idx      <= '0;   // seed word 0 goes to address 0
              state    <= ST_SEED0;
            end else begin
              state <= ST_DIVA;
            end
          end
        end
        ST_DIVA: state <= ST_DIVB;
        ST_DIVB: begin
          third <= prod[63:33];
          state <= ST_DIVC;
        end
        ST_DIVC: begin
          two_third <= prod[63:33];
          wc        <= '0;
          state     <= ST_RD0;
        end
        ST_RD0: state <= ST_RD1;
        ST_RD1: begin
          w0    <= ram_rdata;
          state <= ST_RD2;
        end
        ST_RD2: begin
          w1    <= ram_rdata;
          state <= ST_GEN;
        end
        ST_GEN: begin
          idx   <= idx_next1;
          wc    <= wc + 1'b1;
          state <= ST_RD0;
          if (!wc[0]) begin
            lo <= t;
          end else if (good && !wc[1]) begin
            erased <= (d < erase_threshold);
          end else if (good) begin
            if (d < enter_bad_threshold) good <= 1'b0;
            state <= ST_DONE;
          end else begin
            erased <= 1'b1;
            if (middle || (d < leave_bad_threshold)) good <= 1'b1;
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'b0, good, erased};
            tick     <= 1'b0;
            if (position != '1) position <= position + 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

@@ sim/tb_gilbert_elliott_erasure_channel.sv @@
// Testbench for gilbert_elliott_erasure_channel: random restart ticks checked
// against an in-bench MT19937 / Gilbert-Elliott predictor.
// Depends on gec_pkg and the channel RTL.
module tb_gilbert_elliott_erasure_channel;
  import gec_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TWN = 624;
  localparam int WATCHDOG = 200000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [0] restart
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // [0] erased, [1] in_good_state
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  gilbert_elliott_erasure_channel u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [31:0] mt [TWN];
  int          mt_idx;
  logic        chan_good;
  logic [30:0] pos;
  logic [31:0] seed_reg;
  logic [63:0] thr_erase, thr_enter, thr_leave;
  logic        burst_reg;
  logic [30:0] len_reg;

  logic [7:0]  restart_q [$];   // ticks waiting to be driven
  logic [1:0]  flags_q [$];     // expected {good, erased}
  int          errors, mismatches;
  int          idle_pct, stall_pct;
  int          stall_cnt;
  bit          timed_out;

  function automatic void twister_seed(input logic [31:0] s);
    logic [31:0] p;
    mt[0] = s;
    for (int i = 1; i < TWN; i++) begin
      p = mt[i-1];
      mt[i] = 32'd1812433253 * (p ^ (p >> 30)) + 32'(i);
    end
    mt_idx = TWN;
  endfunction

  function automatic logic [31:0] twister_word();
    logic [31:0] y, v;
    if (mt_idx >= TWN) begin
      for (int k = 0; k < TWN; k++) begin
        y = (mt[k] & 32'h80000000) | (mt[(k+1)%TWN] & 32'h7FFFFFFF);
        v = mt[(k+397)%TWN] ^ (y >> 1);
        if (y[0]) v = v ^ 32'h9908B0DF;
        mt[k] = v;
      end
      mt_idx = 0;
    end
    y = mt[mt_idx];
    mt_idx++;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & 32'h9D2C5680);
    y = y ^ ((y << 15) & 32'hEFC60000);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic logic [63:0] uniform64();
    logic [31:0] lo;
    lo = twister_word();
    return {twister_word(), lo};
  endfunction

  // one channel tick; returns {good after, erased}
  function automatic logic [1:0] channel_tick(input logic restart);
    logic [63:0] d;
    logic [33:0] l2;
    logic        er, mid;
    if (restart) begin
      twister_seed(seed_reg);
      pos = '0;
    end
    if (chan_good) begin
      d = uniform64();
      er = d < thr_erase;
      d = uniform64();
      if (d < thr_enter) chan_good = 1'b0;
    end else begin
      d = uniform64();
      l2 = {3'b0, len_reg} * 2;
      mid = burst_reg && ({3'b0, pos} >= len_reg / 3) && ({3'b0, pos} <= l2 / 3);
      er = 1'b1;
      if (mid || d < thr_leave) chan_good = 1'b1;
    end
    if (pos != 31'h7FFFFFFF) pos = pos + 1;
    return {chan_good, er};
  endfunction

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // driver: each tick is predicted at the transfer edge, so register state
  // seen by the predictor matches what the block sees
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        flags_q.push_back(channel_tick(s_tdata[0]));
        void'(restart_q.pop_front());
      end
      if ((!s_tvalid || s_tready) ) begin
        if (restart_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= restart_q[0];
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
      if (m_tvalid && m_tready) begin
        if (flags_q.size() == 0) begin
          errors++;
          if (mismatches++ < 10) $display("unexpected result %b", m_tdata[1:0]);
        end else begin
          if (m_tdata[1:0] != flags_q[0]) begin
            errors++;
            if (mismatches++ < 10)
              $display("mismatch: expected good=%b erased=%b, got good=%b erased=%b",
                       flags_q[0][1], flags_q[0][0], m_tdata[1], m_tdata[0]);
          end
          void'(flags_q.pop_front());
        end
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cnt <= 0;
    end else if (restart_q.size() != 0 || flags_q.size() != 0) begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= WATCHDOG) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // register write while idle; mirrors into the predictor
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SEED:      seed_reg  = val[31:0];
      REG_ERASE:     thr_erase = val;
      REG_ENTER_BAD: thr_enter = val;
      REG_LEAVE_BAD: thr_leave = val;
      REG_MODE:      burst_reg = val[0];
      REG_LENGTH:    len_reg   = val[30:0];
      default: ;
    endcase
  endtask

  task automatic run_ticks(input int n, input int restart_pct);
    for (int i = 0; i < n; i++)
      restart_q.push_back({7'($urandom), ($urandom_range(99) < restart_pct)});
    while (restart_q.size() != 0 || flags_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_thr();
    case ($urandom_range(5))
      0: return 64'd0;
      1: return '1;
      2: return {$urandom, $urandom};
      default: return {32'($urandom_range(32'hFFFFFFFF)), 32'($urandom)} >> $urandom_range(3);
    endcase
  endfunction

  initial begin
    errors = 0; mismatches = 0;
    idle_pct = 0; stall_pct = 0;
    cfg_we = 0; cfg_index = '0; cfg_data = '0;
    seed_reg = 32'd5489; thr_erase = 0; thr_enter = 0; thr_leave = 0;
    burst_reg = 0; len_reg = 0;
    twister_seed(seed_reg);
    chan_good = 1'b1; pos = '0;
    rst = 1;
    repeat (5) @(posedge clk);
    rst <= 0;

    // directed: reset defaults, then threshold extremes
    run_ticks(4, 0);
    write_reg(REG_ERASE, '1);
    write_reg(REG_ENTER_BAD, 64'd0);
    run_ticks(3, 0);
    write_reg(REG_SEED, 64'hFFFFFFFF);   // takes effect only on restart
    write_reg(REG_ENTER_BAD, '1);
    write_reg(REG_LEAVE_BAD, 64'd0);
    run_ticks(3, 0);
    // burst mode: bad state forced back inside the middle third
    write_reg(REG_MODE, 64'd1);
    write_reg(REG_LENGTH, 64'd9);
    run_ticks(1, 100);
    run_ticks(10, 0);
    write_reg(REG_LENGTH, 64'h7FFFFFFF);
    write_reg(REG_SEED, 64'd0);
    run_ticks(3, 50);
    write_reg(REG_LEAVE_BAD, '1);
    write_reg(REG_LENGTH, 64'd0);
    run_ticks(2, 0);

    // random phases with varied idling
    for (int ph = 0; ph < 24; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 66; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 66; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      write_reg(REG_SEED, {32'd0, $urandom});
      write_reg(REG_ERASE, rand_thr());
      write_reg(REG_ENTER_BAD, rand_thr());
      write_reg(REG_LEAVE_BAD, rand_thr());
      write_reg(REG_MODE, 64'($urandom_range(1)));
      write_reg(REG_LENGTH, ($urandom_range(3) == 0) ? {33'd0, 31'($urandom)}
                                                    : 64'($urandom_range(120)));
      run_ticks(75, 4);
    end

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
